// ----- rtl/chb_pkg.sv -----
// Shared constants for the canonical Huffman bit packer.
package chb_pkg;

  // Fixed field widths of the item and result words
  localparam int SYM_BITS   = 8;
  localparam int CODE_W     = 31;
  localparam int LEN_W      = 5;
  localparam int BYTE_BITS  = 8;

  // Parameter defaults
  localparam int DEF_SYMBOLS       = 256;
  localparam int DEF_MAX_CODE_BITS = 31;

  // Item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

endpackage

// ----- rtl/chb_codebook.sv -----
// Codebook memory: one code word and length per symbol, registered read.
module chb_codebook import chb_pkg::*; #(
  parameter int SYMBOLS       = DEF_SYMBOLS,
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
  localparam int SYM_W        = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [SYM_W-1:0]         waddr,
  input  logic [CODE_W-1:0]        wcode,
  input  logic [LEN_W-1:0]         wlen,
  input  logic                     re,
  input  logic [SYM_W-1:0]         raddr,
  output logic [MAX_CODE_BITS-1:0] rcode,
  output logic [LEN_W-1:0]         rlen
);

  localparam int ENTRY_W = MAX_CODE_BITS + LEN_W;

  logic [ENTRY_W-1:0]       mem [SYMBOLS];
  logic [LEN_W-1:0]         len_sat;
  logic [MAX_CODE_BITS-1:0] code_trim;

  // Saturate the length and drop code bits above the widest code
  always_comb begin
    if (wlen > LEN_W'(MAX_CODE_BITS)) begin
      len_sat = LEN_W'(MAX_CODE_BITS);
    end else begin
      len_sat = wlen;
    end
    code_trim = wcode[MAX_CODE_BITS-1:0];
  end

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {code_trim, len_sat};
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      {rcode, rlen} <= mem[raddr];
    end
  end

endmodule

// ----- rtl/canonical_huffman_bit_packer_unit.sv -----
// Canonical Huffman bit packer: codebook lookup and MSB-first byte packing.
// Load word: written to the codebook on acceptance; the unit stays ready for the next word.
// Encode word: accepted in S_IDLE, looked up and merged in S_MERGE (codebook read),
// then S_EMIT sends the output bytes (0..5, stalled by out_ready) and stores the leftover bits.
// One word is in flight at a time; the codebook read port sets the merge step.
// Reset empties the bit buffer and the output register; the codebook is not cleared.
module canonical_huffman_bit_packer_unit import chb_pkg::*; #(
  parameter int SYMBOLS       = DEF_SYMBOLS,
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [SYM_BITS-1:0] symbol,
  input  logic [CODE_W-1:0]   code_word,
  input  logic [LEN_W-1:0]    code_length,
  input  logic                final_symbol,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                run_last,
  output logic                stream_end
);

  localparam int SYM_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int ACC_W  = MAX_CODE_BITS + BYTE_BITS - 1;
  localparam int NB_W   = $clog2(ACC_W + 1);
  localparam int PEND_W = $clog2(BYTE_BITS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MERGE = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0]               state;
  logic                     fin;
  logic                     sym_ok_r;
  logic [ACC_W-1:0]         acc;
  logic [NB_W-1:0]          nbits;
  logic [BYTE_BITS-1:0]     partial_byte;
  logic [PEND_W-1:0]        pend_bits;

  logic                     accept;
  logic                     sym_ok;
  logic [MAX_CODE_BITS-1:0] rd_code;
  logic [LEN_W-1:0]         rd_len;
  logic [LEN_W-1:0]         len_eff;
  logic [MAX_CODE_BITS-1:0] code_mask;
  logic [ACC_W-1:0]         acc_next;
  logic [NB_W-1:0]          nbits_next;
  logic                     out_free;
  logic                     emit;
  logic [NB_W-1:0]          rem_bits;
  logic [ACC_W-1:0]         acc_shr;
  logic [BYTE_BITS-1:0]     full_byte;
  logic [BYTE_BITS-1:0]     flush_byte;
  logic                     full_last;
  logic [PEND_W:0]          pad_bits;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign sym_ok   = {1'b0, symbol} < (SYM_BITS + 1)'(SYMBOLS);
  assign out_free = !out_valid || out_ready;

  // Load a new output word when a full byte or a tail byte is ready
  assign emit = (state == S_EMIT) && out_free &&
                ((nbits >= NB_W'(BYTE_BITS)) || (fin && (nbits != '0)));

  chb_codebook #(
    .SYMBOLS       (SYMBOLS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_codebook (
    .clk   (clk),
    .we    (accept && (mode == MODE_LOAD) && sym_ok),
    .waddr (symbol[SYM_W-1:0]),
    .wcode (code_word),
    .wlen  (code_length),
    .re    (accept && (mode == MODE_ENCODE)),
    .raddr (symbol[SYM_W-1:0]),
    .rcode (rd_code),
    .rlen  (rd_len)
  );

  // Merge the looked-up code below the pending bits
  always_comb begin
    len_eff    = sym_ok_r ? rd_len : '0;
    code_mask  = ~({MAX_CODE_BITS{1'b1}} << len_eff);
    acc_next   = (ACC_W'(partial_byte) << len_eff) | ACC_W'(rd_code & code_mask);
    nbits_next = NB_W'(pend_bits) + NB_W'(len_eff);
  end

  // Pick the next full byte or the padded tail
  always_comb begin
    rem_bits   = nbits - NB_W'(BYTE_BITS);
    acc_shr    = acc >> rem_bits;
    full_byte  = acc_shr[BYTE_BITS-1:0];
    full_last  = (rem_bits < NB_W'(BYTE_BITS)) && !(fin && (rem_bits != '0));
    pad_bits   = (PEND_W + 1)'(BYTE_BITS) - {1'b0, nbits[PEND_W-1:0]};
    flush_byte = acc[BYTE_BITS-1:0] << pad_bits;
  end

  // Sequencer: accept, merge, emit bytes, store the leftover bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      partial_byte <= '0;
      pend_bits    <= '0;
      out_valid    <= 1'b0;
    end else begin
      // Raise valid for a new word, drop it once the word is taken
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (mode == MODE_ENCODE)) begin
            fin      <= final_symbol;
            sym_ok_r <= sym_ok;
            state    <= S_MERGE;
          end
        end
        S_MERGE: begin
          acc   <= acc_next;
          nbits <= nbits_next;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (nbits >= NB_W'(BYTE_BITS)) begin
            if (out_free) begin
              out_byte   <= full_byte;
              run_last   <= full_last;
              stream_end <= full_last && fin;
              nbits      <= rem_bits;
            end
          end else if (fin && (nbits != '0)) begin
            if (out_free) begin
              out_byte   <= flush_byte;
              run_last   <= 1'b1;
              stream_end <= 1'b1;
              nbits      <= '0;
            end
          end else begin
            // Keep the leftover bits, masked to their count
            partial_byte <= acc[BYTE_BITS-1:0] &
                            ~({BYTE_BITS{1'b1}} << nbits[PEND_W-1:0]);
            pend_bits    <= nbits[PEND_W-1:0];
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/tb_canonical_huffman_bit_packer_unit.sv -----
// Self-checking testbench for the canonical Huffman bit packer: codebook loads, encodes, flushes.
module tb_canonical_huffman_bit_packer_unit;
  import chb_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 11;
  localparam int ENCODE_TARGET  = 250;
  localparam int TAIL_CYCLES    = 20;
  localparam int CYCLE_LIMIT    = 400000;

  // One packed output word as the block should present it
  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 run_last;
    logic                 stream_end;
  } packed_out_t;

  // Tracks the codebook and the pending bit buffer, holds the bytes still owed
  class packed_stream_board;
    logic [CODE_W-1:0] code_tab [256];
    logic [LEN_W-1:0]  len_tab [256];
    logic [63:0]       pend_bits;
    int                pend_cnt;
    packed_out_t       expected_bytes[$];
    int                errors;

    function new();
      pend_bits = '0;
      pend_cnt  = 0;
      errors    = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    // Update the codebook or pack one code and queue the bytes it completes
    function void note_word(logic m, logic [SYM_BITS-1:0] s, logic [CODE_W-1:0] cw,
                            logic [LEN_W-1:0] cl, logic fin);
      logic [63:0]          acc;
      logic [BYTE_BITS-1:0] done_q[$];
      packed_out_t          rec;
      int                   nbits;
      int                   len;
      if (m == MODE_LOAD) begin
        code_tab[s] = cw;
        len_tab[s]  = cl;
        return;
      end
      len   = len_tab[s];
      acc   = (pend_bits << len) | ({33'd0, code_tab[s]} & ((64'd1 << len) - 64'd1));
      nbits = pend_cnt + len;
      // Drain every complete byte, earliest bits first
      while (nbits >= BYTE_BITS) begin
        done_q.push_back(8'(acc >> (nbits - BYTE_BITS)));
        nbits = nbits - BYTE_BITS;
        acc   = acc & ((64'd1 << nbits) - 64'd1);
      end
      // Flush a partial byte left-aligned on the closing symbol
      if (fin && nbits > 0) begin
        done_q.push_back(8'(acc << (BYTE_BITS - nbits)));
        nbits = 0;
        acc   = '0;
      end
      pend_bits = acc;
      pend_cnt  = nbits;
      foreach (done_q[i]) begin
        rec.data       = done_q[i];
        rec.run_last   = (i == done_q.size() - 1);
        rec.stream_end = (i == done_q.size() - 1) && fin;
        expected_bytes.push_back(rec);
      end
    endfunction

    // Compare one accepted output word with the oldest expectation
    function void check_byte(logic [7:0] ob, logic rl, logic se);
      packed_out_t want;
      if (expected_bytes.size() == 0) begin
        $error("out_byte: no word expected, actual %02h", ob);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (ob !== want.data) begin
        $error("out_byte: expected %02h, actual %02h", want.data, ob);
        errors++;
      end
      if (rl !== want.run_last) begin
        $error("run_last: expected %0b, actual %0b", want.run_last, rl);
        errors++;
      end
      if (se !== want.stream_end) begin
        $error("stream_end: expected %0b, actual %0b", want.stream_end, se);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                mode = MODE_LOAD;
  logic [SYM_BITS-1:0] symbol = '0;
  logic [CODE_W-1:0]   code_word = '0;
  logic [LEN_W-1:0]    code_length = '0;
  logic                final_symbol = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_byte;
  logic                run_last;
  logic                stream_end;

  packed_stream_board  sb = new();
  bit                  steady = 1'b0;
  bit                  is_loaded [256];
  logic [SYM_BITS-1:0] loaded_syms[$];
  int                  encoded = 0;
  int                  cycles = 0;

  canonical_huffman_bit_packer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .symbol       (symbol),
    .code_word    (code_word),
    .code_length  (code_length),
    .final_symbol (final_symbol),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .stream_end   (stream_end)
  );

  always #CLK_HALF clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 12);
  endfunction

  // Mostly short codes, some long ones, a few empty
  function automatic logic [LEN_W-1:0] draw_length();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r <= 2) return LEN_W'($urandom_range(24, 31));
    return LEN_W'($urandom_range(1, 12));
  endfunction

  // Present one word at the falling edge and hold it until accepted
  task automatic send_word(input logic m, input logic [SYM_BITS-1:0] s,
                           input logic [CODE_W-1:0] cw, input logic [LEN_W-1:0] cl,
                           input logic fin);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode         = m;
    symbol       = s;
    code_word    = cw;
    code_length  = cl;
    final_symbol = fin;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_word(m, s, cw, cl, fin);
    @(negedge clk);
  endtask

  task automatic load_entry(input logic [SYM_BITS-1:0] s, input logic [CODE_W-1:0] cw,
                            input logic [LEN_W-1:0] cl, input logic fin);
    send_word(MODE_LOAD, s, cw, cl, fin);
    if (!is_loaded[s]) begin
      is_loaded[s] = 1'b1;
      loaded_syms.push_back(s);
    end
  endtask

  task automatic encode_sym(input logic [SYM_BITS-1:0] s, input logic fin);
    send_word(MODE_ENCODE, s, CODE_W'($urandom), LEN_W'($urandom), fin);
    encoded++;
  endtask

  // Accept output words with random back-pressure and check each one
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_byte(out_byte, run_last, stream_end);
      @(negedge clk);
    end
  end

  initial begin
    int n_load;
    int n_sym;
    bit closes;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes of code and length, empty codes, flush corners
    load_entry(8'h00, 31'h0, 5'd1, 1'b0);
    load_entry(8'hFF, 31'h7FFF_FFFF, 5'd31, 1'b0);
    load_entry(8'h5A, 31'h7FFF_FFFF, 5'd3, 1'b1);   // code wider than its length
    load_entry(8'hA5, 31'h55, 5'd0, 1'b0);          // zero-length code
    load_entry(8'h81, 31'h2B, 5'd8, 1'b0);
    encode_sym(8'h00, 1'b0);
    encode_sym(8'hFF, 1'b0);                        // span four bytes
    encode_sym(8'hA5, 1'b1);                        // empty code, nothing left to flush
    encode_sym(8'hA5, 1'b1);                        // flush with nothing pending
    encode_sym(8'h81, 1'b0);                        // exactly one byte
    encode_sym(8'h5A, 1'b0);
    encode_sym(8'hFF, 1'b1);                        // four bytes plus a partial one
    encode_sym(8'h81, 1'b1);                        // byte-aligned close
    load_entry(8'h00, 31'h2AAA_AAAA, 5'd31, 1'b0);  // rewrite an entry
    encode_sym(8'h00, 1'b0);
    encode_sym(8'h5A, 1'b1);
    steady = 1'b1;
    encode_sym(8'hFF, 1'b0);
    encode_sym(8'h81, 1'b0);
    encode_sym(8'h00, 1'b1);
    steady = 1'b0;

    // Random streams: refresh a few entries, encode, mostly close with a flush
    while (encoded < ENCODE_TARGET) begin
      steady = ($urandom_range(0, 4) == 0);
      n_load = $urandom_range(0, 4);
      repeat (n_load) begin
        if ($urandom_range(0, 9) < 7 || loaded_syms.size() == 0)
          load_entry(SYM_BITS'($urandom), CODE_W'($urandom), draw_length(),
                     1'($urandom));
        else
          load_entry(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                     CODE_W'($urandom), draw_length(), 1'($urandom));
      end
      n_sym  = $urandom_range(1, 12);
      closes = ($urandom_range(0, 99) >= 15);
      for (int i = 0; i < n_sym; i++) begin
        // Slip a stray load into the middle of a stream now and then
        if ($urandom_range(0, 9) == 0)
          load_entry(SYM_BITS'($urandom), CODE_W'($urandom), draw_length(),
                     1'($urandom));
        encode_sym(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                   closes && (i == n_sym - 1));
      end
    end
    steady   = 1'b0;
    in_valid = 1'b0;

    // Drain the remaining bytes, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/chb_pkg.sv
rtl/chb_codebook.sv
rtl/canonical_huffman_bit_packer_unit.sv
tb/tb_canonical_huffman_bit_packer_unit.sv
